// ===== sv/assert_macros.svh =====
// Assertion helpers for the vignette brighten block.
// Each macro samples on i_clk and is switched off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds in the same cycle.
`define RVB_ASSERT_NOW(lbl, pre, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (cond)) \
        else $error("assertion failed: lbl");

// Check that a condition holds in the cycle after the trigger.
`define RVB_ASSERT_NEXT(lbl, pre, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (cond)) \
        else $error("assertion failed: lbl");

`endif

// ===== sv/rvb_pkg.sv =====
// ----------------------------------------------------------------------------
// rvb_pkg
// Types and constants shared by the radial vignette brighten block.
// ----------------------------------------------------------------------------
package rvb_pkg;

    // Field widths
    localparam int POS_W    = 12;
    localparam int DIM_W    = 13;
    localparam int RATIO_W  = 17;
    localparam int GAIN_W   = 32;
    localparam int CH_W     = 8;
    localparam int SCALED_W = POS_W + RATIO_W;       // 29
    localparam int SSQ_W    = 2 * SCALED_W;          // 58
    localparam int PSQ_W    = 2 * POS_W;             // 24
    localparam int DIST_W   = SSQ_W - 32 + 1;        // 27
    localparam int PROD_W   = DIST_W + GAIN_W;       // 59
    localparam int ADD_W    = PROD_W - 24;           // 35

    // Pipeline depth
    localparam int NSTG = 6;

    // Configuration register indexes
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_AXIS_RATIO   = 2'd2;
    localparam logic [1:0] CFG_GAIN         = 2'd3;

    // Configuration reset values
    localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT = 13'd480;
    localparam logic [RATIO_W-1:0] RST_AXIS_RATIO   = 17'd49152;
    localparam logic [GAIN_W-1:0]  RST_GAIN         = 32'd53477;

    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

    typedef struct packed {
        logic [POS_W-1:0] col_pos;
        logic [POS_W-1:0] row_pos;
        logic [CH_W-1:0]  blue_in;
        logic [CH_W-1:0]  green_in;
        logic [CH_W-1:0]  red_in;
    } t_pix_in;

    typedef struct packed {
        logic [CH_W-1:0] blue_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] red_out;
    } t_pix_out;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_rgb;

    typedef struct packed {
        logic [DIM_W-1:0]   frame_width;
        logic [DIM_W-1:0]   frame_height;
        logic [RATIO_W-1:0] axis_ratio_q16;
        logic [GAIN_W-1:0]  gain_q24;
    } t_cfg;

    // Per-stage advance enables
    typedef struct packed {
        logic [NSTG-1:0] adv;
    } t_pipe_ctrl;

    // Stage one result: offset magnitudes
    typedef struct packed {
        logic [POS_W-1:0] long_mag;
        logic [POS_W-1:0] plain_mag;
        t_rgb             rgb;
    } t_ofs;

    // Stage four result: integer squared distance
    typedef struct packed {
        logic [DIST_W-1:0] dist_sq;
        t_rgb              rgb;
    } t_dist;

endpackage

// ===== sv/radial_vignette_brighten_unit.sv =====
// ----------------------------------------------------------------------------
// radial_vignette_brighten_unit
// Brightens each BGR pixel by a gain times its squared, axis-scaled distance
// from the frame centre, saturating every channel at 255.
//
//   channel   direction  handshake             word
//   pixel in  in         i_valid / o_stall     t_pix_in  (col, row, B, G, R)
//   pixel out out        o_valid / i_stall     t_pix_out (B, G, R)
//   config    in         i_cfg_valid / o_cfg_ready  index + 32-bit data
//
// One pixel per clock while the output is not stalled; the six-stage pipeline
// runs offset, scale, square, sum, gain multiply, saturate and output.
// Reset loads the default frame size, ratio and gain and empties the pipe.
// A stall on the output holds the last stage; empty stages still fill, so
// o_stall rises only when every stage holds a word.
// The configuration port is always ready; a write takes effect next cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module radial_vignette_brighten_unit
    import rvb_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_pix_in     i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_pix_out    o_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg            cfg;
    t_pipe_ctrl      ctrl;
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    t_ofs            ofs;
    t_dist           dsum;

    assign o_cfg_ready = 1'b1;

    rvb_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Advance a stage when it is empty or its successor advances
    always_comb begin
        ctrl.adv[NSTG-1] = !r_vld[NSTG-1] || !i_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            ctrl.adv[k] = !r_vld[k] || ctrl.adv[k+1];
        end
    end

    assign o_stall = !ctrl.adv[0];

    // Move valid bits along with the data
    always_comb begin
        n_vld = r_vld;
        if (ctrl.adv[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (ctrl.adv[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    rvb_offset u_offset (
        .i_clk (i_clk),
        .i_adv (ctrl.adv[0]),
        .i_pix (i_data),
        .i_cfg (cfg),
        .o_ofs (ofs)
    );

    rvb_dist u_dist (
        .i_clk   (i_clk),
        .i_adv   (ctrl.adv[3:1]),
        .i_ofs   (ofs),
        .i_ratio (cfg.axis_ratio_q16),
        .o_dist  (dsum)
    );

    rvb_gain u_gain (
        .i_clk  (i_clk),
        .i_adv  (ctrl.adv[5:4]),
        .i_dist (dsum),
        .i_gain (cfg.gain_q24),
        .o_pix  (o_data)
    );

    assign o_valid = r_vld[NSTG-1];

    // Back-pressure reaches the input only with a full pipe
    `RVB_ASSERT_NOW(a_stall_full, o_stall, ((&r_vld) && i_stall))
    // An accepted word lands in stage one
    `RVB_ASSERT_NEXT(a_accept_lands, (i_valid && !o_stall), r_vld[0])
    // A held result keeps its valid while stalled
    `RVB_ASSERT_NEXT(a_out_hold, (o_valid && i_stall), o_valid)
    // Frame sizes never exceed the maximum dimension
    `RVB_ASSERT_NOW(a_dim_clamp, 1'b1,
        ((32'(cfg.frame_width) <= 32'(MAX_DIM)) && (32'(cfg.frame_height) <= 32'(MAX_DIM))))

endmodule

// ===== sv/rvb_cfg.sv =====
// ----------------------------------------------------------------------------
// rvb_cfg
// Configuration register file; frame sizes are clamped to the maximum dimension.
// ----------------------------------------------------------------------------
module rvb_cfg
    import rvb_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg             r_cfg;
    t_cfg             n_cfg;
    logic [DIM_W-1:0] dim_clamped;

    // Clamp a written dimension to the maximum
    always_comb begin
        if (32'(i_cfg_data[DIM_W-1:0]) > 32'(MAX_DIM)) begin
            dim_clamped = DIM_W'(MAX_DIM);
        end else begin
            dim_clamped = i_cfg_data[DIM_W-1:0];
        end
    end

    // Decode the register index
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  n_cfg.frame_width    = dim_clamped;
                CFG_FRAME_HEIGHT: n_cfg.frame_height   = dim_clamped;
                CFG_AXIS_RATIO:   n_cfg.axis_ratio_q16 = i_cfg_data[RATIO_W-1:0];
                CFG_GAIN:         n_cfg.gain_q24       = i_cfg_data[GAIN_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width    <= RST_FRAME_WIDTH;
            r_cfg.frame_height   <= RST_FRAME_HEIGHT;
            r_cfg.axis_ratio_q16 <= RST_AXIS_RATIO;
            r_cfg.gain_q24       <= RST_GAIN;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/rvb_offset.sv =====
// ----------------------------------------------------------------------------
// rvb_offset
// Stage one: offsets from the frame centre, sorted into long and short axis.
// ----------------------------------------------------------------------------
module rvb_offset
    import rvb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_adv,
    input  t_pix_in i_pix,
    input  t_cfg    i_cfg,
    output t_ofs    o_ofs
);

    logic [POS_W-1:0] cx;
    logic [POS_W-1:0] cy;
    logic [POS_W-1:0] mx;
    logic [POS_W-1:0] my;
    logic             wide;
    t_ofs             n_ofs;
    t_ofs             r_ofs;

    // Centre by halving, then absolute offsets
    always_comb begin
        cx   = i_cfg.frame_width[DIM_W-1:1];
        cy   = i_cfg.frame_height[DIM_W-1:1];
        mx   = (cx >= i_pix.col_pos) ? (cx - i_pix.col_pos) : (i_pix.col_pos - cx);
        my   = (cy >= i_pix.row_pos) ? (cy - i_pix.row_pos) : (i_pix.row_pos - cy);
        wide = (i_cfg.frame_width > i_cfg.frame_height);
        n_ofs.long_mag  = wide ? mx : my;
        n_ofs.plain_mag = wide ? my : mx;
        n_ofs.rgb.blue  = i_pix.blue_in;
        n_ofs.rgb.green = i_pix.green_in;
        n_ofs.rgb.red   = i_pix.red_in;
    end

    // Advance the stage register
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ofs <= n_ofs;
        end
    end

    assign o_ofs = r_ofs;

endmodule

// ===== sv/rvb_dist.sv =====
// ----------------------------------------------------------------------------
// rvb_dist
// Stages two to four: scale the long axis, square both offsets, sum to an
// integer squared distance.
// ----------------------------------------------------------------------------
module rvb_dist
    import rvb_pkg::*;
(
    input  logic               i_clk,
    input  logic [2:0]         i_adv,
    input  t_ofs               i_ofs,
    input  logic [RATIO_W-1:0] i_ratio,
    output t_dist              o_dist
);

    logic [SCALED_W-1:0] r_scaled;
    logic [PSQ_W-1:0]    r_psq2;
    t_rgb                r_rgb2;
    logic [SSQ_W-1:0]    r_ssq;
    logic [PSQ_W-1:0]    r_psq3;
    t_rgb                r_rgb3;
    t_dist               r_dist;

    // Stage two: scale the long offset, square the short one
    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_scaled <= SCALED_W'(i_ofs.long_mag) * SCALED_W'(i_ratio);
            r_psq2   <= PSQ_W'(i_ofs.plain_mag) * PSQ_W'(i_ofs.plain_mag);
            r_rgb2   <= i_ofs.rgb;
        end
    end

    // Stage three: square the scaled offset (Q.32)
    always_ff @(posedge i_clk) begin
        if (i_adv[1]) begin
            r_ssq  <= SSQ_W'(r_scaled) * SSQ_W'(r_scaled);
            r_psq3 <= r_psq2;
            r_rgb3 <= r_rgb2;
        end
    end

    // Stage four: drop the fraction and add the plain square
    always_ff @(posedge i_clk) begin
        if (i_adv[2]) begin
            r_dist.dist_sq <= DIST_W'(r_ssq[SSQ_W-1:32]) + DIST_W'(r_psq3);
            r_dist.rgb     <= r_rgb3;
        end
    end

    assign o_dist = r_dist;

endmodule

// ===== sv/rvb_gain.sv =====
// ----------------------------------------------------------------------------
// rvb_gain
// Stages five and six: apply the gain and add to each channel with saturation.
// ----------------------------------------------------------------------------
module rvb_gain
    import rvb_pkg::*;
(
    input  logic              i_clk,
    input  logic [1:0]        i_adv,
    input  t_dist             i_dist,
    input  logic [GAIN_W-1:0] i_gain,
    output t_pix_out          o_pix
);

    logic [PROD_W-1:0] prod;
    logic [ADD_W-1:0]  r_add;
    t_rgb              r_rgb5;
    t_pix_out          n_pix;
    t_pix_out          r_pix;
    logic              add_big;
    logic [CH_W:0]     sum_b;
    logic [CH_W:0]     sum_g;
    logic [CH_W:0]     sum_r;

    assign prod = PROD_W'(i_dist.dist_sq) * PROD_W'(i_gain);

    // Stage five: gain product, floored from Q.24
    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_add  <= prod[PROD_W-1:24];
            r_rgb5 <= i_dist.rgb;
        end
    end

    // Saturating channel add
    always_comb begin
        add_big = (r_add >= ADD_W'(CH_MAX));
        sum_b   = {1'b0, r_rgb5.blue}  + {1'b0, r_add[CH_W-1:0]};
        sum_g   = {1'b0, r_rgb5.green} + {1'b0, r_add[CH_W-1:0]};
        sum_r   = {1'b0, r_rgb5.red}   + {1'b0, r_add[CH_W-1:0]};
        n_pix.blue_out  = (add_big || sum_b[CH_W]) ? CH_MAX : sum_b[CH_W-1:0];
        n_pix.green_out = (add_big || sum_g[CH_W]) ? CH_MAX : sum_g[CH_W-1:0];
        n_pix.red_out   = (add_big || sum_r[CH_W]) ? CH_MAX : sum_r[CH_W-1:0];
    end

    // Stage six: output register
    always_ff @(posedge i_clk) begin
        if (i_adv[1]) begin
            r_pix <= n_pix;
        end
    end

    assign o_pix = r_pix;

endmodule
